@@ src/fcvr_pkg.sv @@
package fcvr_pkg;

	// Item kinds on the command channel
	typedef enum logic [1:0] {
		OP_ODOM  = 2'd0,
		OP_CMD   = 2'd1,
		OP_RESET = 2'd2
	} op_t;

	// Register index of the field-mode switch (byte address 4*index)
	localparam logic REG_FIELD_MODE = 1'b0;

	// CORDIC datapath widths: x/y hold the Q.30 vector with gain growth,
	// z holds the angle in units of 2^-32 turn
	localparam int CORDIC_TABLE_LEN = 24;
	localparam int CORDIC_XW        = 36;
	localparam int CORDIC_ZW        = 34;
	localparam int CORDIC_IW        = 5;

	// Width of the multiplicand side of the serial multiplier
	localparam int MUL_PW = 33;

	localparam int Q30_SHIFT = 30;

	localparam logic signed [CORDIC_XW-1:0] CORDIC_INV_GAIN = 36'sd652032874;
	localparam logic signed [CORDIC_XW-1:0] ONE_Q30         = 36'sd1073741824;
	localparam logic signed [CORDIC_ZW-1:0] Z_HALF_TURN     = 34'sd2147483648;
	localparam logic signed [CORDIC_ZW-1:0] Z_YAW_ROUND     = 34'sd32768;
	localparam logic signed [31:0]          ROUND_HALF_Q30  = 32'sd536870912;
	localparam logic signed [15:0]          ANG_QUARTER     = 16'sd16384;

	// Handshake between the sequencer and the CORDIC unit
	typedef struct packed {
		logic start;
		logic vectoring;
	} cordic_req_t;

	typedef struct packed {
		logic busy;
		logic done;
	} cordic_stat_t;

	// atan(2^-i) in units of 2^-32 turn
	function automatic logic [31:0] atan_turn(input logic [CORDIC_IW-1:0] idx);
		logic [31:0] a;
		case (idx)
			5'd0:    a = 32'd536870912;
			5'd1:    a = 32'd316933406;
			5'd2:    a = 32'd167458907;
			5'd3:    a = 32'd85004756;
			5'd4:    a = 32'd42667331;
			5'd5:    a = 32'd21354465;
			5'd6:    a = 32'd10680862;
			5'd7:    a = 32'd5340245;
			5'd8:    a = 32'd2670163;
			5'd9:    a = 32'd1335087;
			5'd10:   a = 32'd667544;
			5'd11:   a = 32'd333772;
			5'd12:   a = 32'd166886;
			5'd13:   a = 32'd83443;
			5'd14:   a = 32'd41722;
			5'd15:   a = 32'd20861;
			5'd16:   a = 32'd10430;
			5'd17:   a = 32'd5215;
			5'd18:   a = 32'd2608;
			5'd19:   a = 32'd1304;
			5'd20:   a = 32'd652;
			5'd21:   a = 32'd326;
			5'd22:   a = 32'd163;
			5'd23:   a = 32'd81;
			default: a = 32'd0;
		endcase
		return a;
	endfunction

endpackage

@@ src/fcvr_ifs.sv @@
// Command channel: odometry, velocity command and heading reset words
interface fcvr_cmd_if #(parameter int DATA_WIDTH = 16);
	logic                         valid;
	logic                         ready;
	logic [1:0]                   operation;
	logic signed [15:0]           quat_w;
	logic signed [15:0]           quat_x;
	logic signed [15:0]           quat_y;
	logic signed [15:0]           quat_z;
	logic signed [DATA_WIDTH-1:0] cmd_vx;
	logic signed [DATA_WIDTH-1:0] cmd_vy;
	logic signed [DATA_WIDTH-1:0] omega_in;

	modport source (
		output valid, operation, quat_w, quat_x, quat_y, quat_z, cmd_vx, cmd_vy, omega_in,
		input  ready
	);
	modport sink (
		input  valid, operation, quat_w, quat_x, quat_y, quat_z, cmd_vx, cmd_vy, omega_in,
		output ready
	);
endinterface

// Result channel: robot-frame velocity words
interface fcvr_res_if #(parameter int DATA_WIDTH = 16);
	logic                         valid;
	logic                         ready;
	logic signed [DATA_WIDTH-1:0] out_vx;
	logic signed [DATA_WIDTH-1:0] out_vy;
	logic signed [DATA_WIDTH-1:0] out_omega;
	logic                         was_rotated;

	modport source (
		output valid, out_vx, out_vy, out_omega, was_rotated,
		input  ready
	);
	modport sink (
		input  valid, out_vx, out_vy, out_omega, was_rotated,
		output ready
	);
endinterface

@@ src/fcvr_smac.sv @@
// Serial dual multiply-accumulate, one multiplier bit per cycle, MSB first:
//   acc0 = m0*p0 + m1*p1,  acc1 = m1*p2 + m0*p3
module fcvr_smac #(
	parameter int MW = 16,
	parameter int PW = 33
) (
	input  logic                     clk,
	input  logic                     arst_n,
	input  logic                     start,
	input  logic signed [MW-1:0]     m0,
	input  logic signed [MW-1:0]     m1,
	input  logic signed [PW-1:0]     p0,
	input  logic signed [PW-1:0]     p1,
	input  logic signed [PW-1:0]     p2,
	input  logic signed [PW-1:0]     p3,
	output logic                     done,
	output logic signed [MW+PW:0]    acc0,
	output logic signed [MW+PW:0]    acc1
);

	localparam int AW = MW + PW + 1;
	localparam int CW = $clog2(MW);

	logic              busy_q;
	logic              done_q;
	logic              first_q;
	logic [CW-1:0]     cnt_q;
	logic [MW-1:0]     m0_q;
	logic [MW-1:0]     m1_q;
	logic signed [PW-1:0] p0_q, p1_q, p2_q, p3_q;
	logic signed [AW-1:0] acc0_q, acc1_q;
	logic signed [AW-1:0] t0, t1;
	logic signed [AW-1:0] e0, e1, e2, e3;
	logic              last;

	assign last = (cnt_q == CW'(MW - 1));

	// Partial products for the current multiplier bits; the sign bit weighs negative
	always_comb begin
		e0 = AW'(p0_q);
		e1 = AW'(p1_q);
		e2 = AW'(p2_q);
		e3 = AW'(p3_q);
		t0 = (m0_q[MW-1] ? e0 : '0) + (m1_q[MW-1] ? e1 : '0);
		t1 = (m1_q[MW-1] ? e2 : '0) + (m0_q[MW-1] ? e3 : '0);
		if (first_q) begin
			t0 = -t0;
			t1 = -t1;
		end
	end

	// Control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q  <= 1'b0;
			done_q  <= 1'b0;
			first_q <= 1'b0;
			cnt_q   <= '0;
		end else begin
			done_q <= busy_q && last;
			if (start) begin
				busy_q  <= 1'b1;
				first_q <= 1'b1;
				cnt_q   <= '0;
			end else if (busy_q) begin
				first_q <= 1'b0;
				cnt_q   <= cnt_q + CW'(1);
				if (last) begin
					busy_q <= 1'b0;
				end
			end
		end
	end

	// Operand shift registers and accumulators
	always_ff @(posedge clk) begin
		if (start) begin
			m0_q   <= m0;
			m1_q   <= m1;
			p0_q   <= p0;
			p1_q   <= p1;
			p2_q   <= p2;
			p3_q   <= p3;
			acc0_q <= '0;
			acc1_q <= '0;
		end else if (busy_q) begin
			m0_q   <= {m0_q[MW-2:0], 1'b0};
			m1_q   <= {m1_q[MW-2:0], 1'b0};
			acc0_q <= (acc0_q <<< 1) + t0;
			acc1_q <= (acc1_q <<< 1) + t1;
		end
	end

	assign done = done_q;
	assign acc0 = acc0_q;
	assign acc1 = acc1_q;

endmodule

@@ src/fcvr_cordic.sv @@
// Iterative CORDIC, one micro-rotation per cycle.
// Vectoring: atan2(vec_y, vec_x) as a 16-bit binary angle on yaw.
// Rotation: cos/sin in Q.30 of angle on cos_out/sin_out.
module fcvr_cordic #(
	parameter int STEPS = 16
) (
	input  logic                                      clk,
	input  logic                                      arst_n,
	input  fcvr_pkg::cordic_req_t                     req,
	input  logic signed [fcvr_pkg::CORDIC_XW-1:0]     vec_x,
	input  logic signed [fcvr_pkg::CORDIC_XW-1:0]     vec_y,
	input  logic [15:0]                               angle,
	output fcvr_pkg::cordic_stat_t                    stat,
	output logic signed [fcvr_pkg::CORDIC_XW-1:0]     cos_out,
	output logic signed [fcvr_pkg::CORDIC_XW-1:0]     sin_out,
	output logic [15:0]                               yaw
);

	localparam int XW = fcvr_pkg::CORDIC_XW;
	localparam int ZW = fcvr_pkg::CORDIC_ZW;
	localparam int IW = fcvr_pkg::CORDIC_IW;

	logic                 busy_q, done_q;
	logic [IW-1:0]        i_q;
	logic                 vec_q, flip_q, zero_q;
	logic signed [XW-1:0] x_q, y_q;
	logic signed [ZW-1:0] z_q;

	logic signed [XW-1:0] xs, ys;
	logic signed [ZW-1:0] at;
	logic                 dpos, same, last;
	logic signed [ZW-1:0] z_ang, z_rot0;
	logic                 rot_flip;
	logic signed [ZW-1:0] yaw_sum;

	assign last = (i_q == IW'(STEPS - 1));

	// Rotation start: fold the angle into [-quarter, +quarter] turn
	always_comb begin
		z_ang    = {{(ZW-32){angle[15]}}, angle, 16'h0000};
		rot_flip = 1'b0;
		z_rot0   = z_ang;
		if ($signed(angle) > fcvr_pkg::ANG_QUARTER) begin
			z_rot0   = z_ang - fcvr_pkg::Z_HALF_TURN;
			rot_flip = 1'b1;
		end else if ($signed(angle) < -fcvr_pkg::ANG_QUARTER) begin
			z_rot0   = z_ang + fcvr_pkg::Z_HALF_TURN;
			rot_flip = 1'b1;
		end
	end

	// One micro-rotation: direction from y in vectoring, from z in rotation
	always_comb begin
		xs   = x_q >>> i_q;
		ys   = y_q >>> i_q;
		at   = ZW'(fcvr_pkg::atan_turn(i_q));
		dpos = vec_q ? ~y_q[XW-1] : ~z_q[ZW-1];
		same = (vec_q == dpos);
	end

	// Control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			i_q    <= '0;
		end else begin
			done_q <= busy_q && last;
			if (req.start) begin
				busy_q <= 1'b1;
				i_q    <= '0;
			end else if (busy_q) begin
				i_q <= i_q + IW'(1);
				if (last) begin
					busy_q <= 1'b0;
				end
			end
		end
	end

	// Datapath
	always_ff @(posedge clk) begin
		if (req.start) begin
			vec_q <= req.vectoring;
			if (req.vectoring) begin
				flip_q <= 1'b0;
				zero_q <= (vec_x == '0) && (vec_y == '0);
				if (vec_x[XW-1]) begin
					x_q <= -vec_x;
					y_q <= -vec_y;
					z_q <= fcvr_pkg::Z_HALF_TURN;
				end else begin
					x_q <= vec_x;
					y_q <= vec_y;
					z_q <= '0;
				end
			end else begin
				flip_q <= rot_flip;
				zero_q <= 1'b0;
				x_q    <= fcvr_pkg::CORDIC_INV_GAIN;
				y_q    <= '0;
				z_q    <= z_rot0;
			end
		end else if (busy_q) begin
			x_q <= same ? x_q + ys : x_q - ys;
			y_q <= same ? y_q - xs : y_q + xs;
			z_q <= same ? z_q + at : z_q - at;
		end
	end

	// Results
	assign yaw_sum = z_q + fcvr_pkg::Z_YAW_ROUND;
	assign yaw     = zero_q ? 16'h0000 : yaw_sum[31:16];
	assign cos_out = flip_q ? -x_q : x_q;
	assign sin_out = flip_q ? -y_q : y_q;
	assign stat    = '{busy: busy_q, done: done_q};

endmodule

@@ src/field_centric_velocity_rotator_top.sv @@
// Field-centric velocity rotator.
// cmd (valid/ready) carries three word kinds chosen by operation: odometry
// (quaternion -> yaw via atan2), velocity command (gives one res word) and
// heading reset (offset := current yaw). Unused codes are dropped.
// res (valid/ready) returns the robot-frame velocity; omega is copied, and
// was_rotated tells whether the yaw-minus-offset rotation was applied.
// APB port: register 0 (address 0) is the field-mode switch, reset value 1.
// Steps: odometry runs the serial quaternion products, then the vectoring
// CORDIC; a rotated command runs the rotation CORDIC, then the serial
// velocity products, then its res word is registered; a pass-through
// command goes straight to the output register; heading reset and unused
// codes use neither unit. The serial multiplier (one multiplier bit per
// cycle) and the CORDIC unit (one micro-rotation per cycle) do the work;
// one word is in work at a time. A finished res word sits in an output
// register; odometry and reset words are still taken while res is
// stalled, and a taken command waits for the register to drain. Reset
// clears yaw, offset, the odometry-seen flag and any pending res word.
module field_centric_velocity_rotator_top #(
	parameter int CORDIC_STEPS = 16,
	parameter int DATA_WIDTH   = 16
) (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         psel,
	input  logic         penable,
	input  logic         pwrite,
	input  logic [2:0]   paddr,
	input  logic [31:0]  pwdata,
	output logic [31:0]  prdata,
	output logic         pready,
	fcvr_cmd_if.sink     cmd,
	fcvr_res_if.source   res
);

	localparam int STEPS = (CORDIC_STEPS > fcvr_pkg::CORDIC_TABLE_LEN) ?
		fcvr_pkg::CORDIC_TABLE_LEN : CORDIC_STEPS;
	localparam int MW = (DATA_WIDTH > 16) ? DATA_WIDTH : 16;
	localparam int PW = fcvr_pkg::MUL_PW;
	localparam int AW = MW + PW + 1;
	localparam int XW = fcvr_pkg::CORDIC_XW;

	localparam logic signed [AW-1:0] RND     = AW'(fcvr_pkg::ROUND_HALF_Q30);
	localparam logic signed [AW-1:0] OUT_MAX = AW'((64'sd1 <<< (DATA_WIDTH - 1)) - 64'sd1);
	localparam logic signed [AW-1:0] OUT_MIN = -OUT_MAX - AW'(1);

	typedef enum logic [5:0] {
		S_IDLE = 6'b000001,
		S_QMUL = 6'b000010,
		S_VEC  = 6'b000100,
		S_ROT  = 6'b001000,
		S_CMUL = 6'b010000,
		S_EMIT = 6'b100000
	} state_t;

	state_t state_q;

	logic                         ugf_q;
	logic [15:0]                  yaw_q;
	logic [15:0]                  offset_q;
	logic                         seen_q;
	logic                         rot_q;
	logic signed [DATA_WIDTH-1:0] vx_q, vy_q, om_q;

	logic                         res_valid_q;
	logic signed [DATA_WIDTH-1:0] res_vx_q, res_vy_q, res_om_q;
	logic                         res_rot_q;

	logic cmd_acc, cfg_wr, rotate_now, emit_go;

	fcvr_pkg::cordic_req_t  creq;
	fcvr_pkg::cordic_stat_t cstat;
	logic signed [XW-1:0]   c_vx, c_vy, c_cos, c_sin;
	logic [15:0]            c_yaw;

	logic                 mac_start, mac_done;
	logic signed [MW-1:0] m0, m1;
	logic signed [PW-1:0] p0, p1, p2, p3;
	logic signed [AW-1:0] acc0, acc1;

	logic signed [AW-1:0]         rx, ry;
	logic signed [DATA_WIDTH-1:0] sx, sy;

	// Configuration port
	assign pready = 1'b1;
	assign cfg_wr = psel && penable && pwrite && (paddr[2] == fcvr_pkg::REG_FIELD_MODE);
	assign prdata = (paddr[2] == fcvr_pkg::REG_FIELD_MODE) ? {31'd0, ugf_q} : 32'd0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ugf_q <= 1'b1;
		end else if (cfg_wr) begin
			ugf_q <= pwdata[0];
		end
	end

	// Handshakes
	assign cmd.ready  = (state_q == S_IDLE);
	assign cmd_acc    = cmd.valid && cmd.ready;
	assign rotate_now = ugf_q && seen_q;
	assign emit_go    = (state_q == S_EMIT) && (!res_valid_q || res.ready);

	// Unit starts
	assign mac_start = (cmd_acc && (cmd.operation == fcvr_pkg::OP_ODOM)) ||
		((state_q == S_ROT) && cstat.done);
	assign creq = '{
		start: (cmd_acc && (cmd.operation == fcvr_pkg::OP_CMD) && rotate_now) ||
			((state_q == S_QMUL) && mac_done),
		vectoring: (state_q == S_QMUL)
	};

	// Multiplier operands: quaternion products or velocity rotation
	always_comb begin
		if (state_q == S_IDLE) begin
			m0 = MW'(cmd.quat_z);
			m1 = MW'(cmd.quat_y);
			p0 = PW'(cmd.quat_w);
			p1 = PW'(cmd.quat_x);
			p2 = PW'(cmd.quat_y);
			p3 = PW'(cmd.quat_z);
		end else begin
			m0 = MW'(vx_q);
			m1 = MW'(vy_q);
			p0 = PW'(c_cos);
			p1 = PW'(c_sin);
			p2 = PW'(c_cos);
			p3 = PW'(-c_sin);
		end
	end

	// s = 2(wz+xy), c = 1 - 2(y^2+z^2) in Q.30
	assign c_vy = {acc0[XW-2:0], 1'b0};
	assign c_vx = fcvr_pkg::ONE_Q30 - {acc1[XW-2:0], 1'b0};

	fcvr_smac #(
		.MW (MW),
		.PW (PW)
	) u_smac (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (mac_start),
		.m0     (m0),
		.m1     (m1),
		.p0     (p0),
		.p1     (p1),
		.p2     (p2),
		.p3     (p3),
		.done   (mac_done),
		.acc0   (acc0),
		.acc1   (acc1)
	);

	fcvr_cordic #(
		.STEPS (STEPS)
	) u_cordic (
		.clk     (clk),
		.arst_n  (arst_n),
		.req     (creq),
		.vec_x   (c_vx),
		.vec_y   (c_vy),
		.angle   (yaw_q - offset_q),
		.stat    (cstat),
		.cos_out (c_cos),
		.sin_out (c_sin),
		.yaw     (c_yaw)
	);

	// Round Q.30 sums to Q8.8 and saturate
	always_comb begin
		rx = (acc0 + RND) >>> fcvr_pkg::Q30_SHIFT;
		ry = (acc1 + RND) >>> fcvr_pkg::Q30_SHIFT;
		if (rx > OUT_MAX) begin
			sx = OUT_MAX[DATA_WIDTH-1:0];
		end else if (rx < OUT_MIN) begin
			sx = OUT_MIN[DATA_WIDTH-1:0];
		end else begin
			sx = rx[DATA_WIDTH-1:0];
		end
		if (ry > OUT_MAX) begin
			sy = OUT_MAX[DATA_WIDTH-1:0];
		end else if (ry < OUT_MIN) begin
			sy = OUT_MIN[DATA_WIDTH-1:0];
		end else begin
			sy = ry[DATA_WIDTH-1:0];
		end
	end

	// Sequencer and heading state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= S_IDLE;
			yaw_q    <= '0;
			offset_q <= '0;
			seen_q   <= 1'b0;
			rot_q    <= 1'b0;
		end else begin
			case (state_q)
				S_IDLE: begin
					if (cmd_acc) begin
						case (cmd.operation)
							fcvr_pkg::OP_ODOM: begin
								state_q <= S_QMUL;
							end
							fcvr_pkg::OP_CMD: begin
								rot_q   <= rotate_now;
								state_q <= rotate_now ? S_ROT : S_EMIT;
							end
							fcvr_pkg::OP_RESET: begin
								offset_q <= yaw_q;
							end
							default: begin
							end
						endcase
					end
				end
				S_QMUL: begin
					if (mac_done) begin
						state_q <= S_VEC;
					end
				end
				S_VEC: begin
					if (cstat.done) begin
						yaw_q <= c_yaw;
						if (!seen_q) begin
							offset_q <= c_yaw;
							seen_q   <= 1'b1;
						end
						state_q <= S_IDLE;
					end
				end
				S_ROT: begin
					if (cstat.done) begin
						state_q <= S_CMUL;
					end
				end
				S_CMUL: begin
					if (mac_done) begin
						state_q <= S_EMIT;
					end
				end
				S_EMIT: begin
					if (emit_go) begin
						state_q <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	// Command payload
	always_ff @(posedge clk) begin
		if (cmd_acc && (cmd.operation == fcvr_pkg::OP_CMD)) begin
			vx_q <= cmd.cmd_vx;
			vy_q <= cmd.cmd_vy;
			om_q <= cmd.omega_in;
		end
	end

	// Output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_valid_q <= 1'b0;
		end else if (emit_go) begin
			res_valid_q <= 1'b1;
		end else if (res.ready) begin
			res_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (emit_go) begin
			res_vx_q  <= rot_q ? sx : vx_q;
			res_vy_q  <= rot_q ? sy : vy_q;
			res_om_q  <= om_q;
			res_rot_q <= rot_q;
		end
	end

	assign res.valid       = res_valid_q;
	assign res.out_vx      = res_vx_q;
	assign res.out_vy      = res_vy_q;
	assign res.out_omega   = res_om_q;
	assign res.was_rotated = res_rot_q;

	// A rotated result needs a heading from odometry
	a_rot_needs_odom: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid_q |-> (!res_rot_q || seen_q))
		else $error("rotated result without odometry");

	// The CORDIC unit is never restarted mid-run
	a_cordic_start_idle: assert property (@(posedge clk) disable iff (!arst_n)
		creq.start |-> !cstat.busy)
		else $error("CORDIC started while busy");

	// Multiplier completes only in the states that wait on it
	a_mac_done_state: assert property (@(posedge clk) disable iff (!arst_n)
		mac_done |-> (state_q == S_QMUL || state_q == S_CMUL))
		else $error("multiplier done in wrong state");

	// CORDIC completes only in the states that wait on it
	a_cordic_done_state: assert property (@(posedge clk) disable iff (!arst_n)
		cstat.done |-> (state_q == S_VEC || state_q == S_ROT))
		else $error("CORDIC done in wrong state");

	// A result held back by a full output register is not lost
	a_emit_holds: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_EMIT && res_valid_q && !res.ready) |=> (state_q == S_EMIT))
		else $error("result dropped while output stalled");

endmodule

@@ sim/tb.sv @@
module tb;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int CLK_PERIOD    = 10;
	localparam int ROT_STEPS     = 16;
	localparam int VEL_W         = 16;
	localparam int SETTLE_CYCLES = 48;    // longer than an odometry word
	localparam int HOLD_CYCLES   = 300;
	localparam int QUIET_LIMIT   = 4000;
	localparam int PRINT_CAP     = 50;

	localparam logic [1:0] OP_SPARE        = 2'd3;
	localparam logic [2:0] FIELD_MODE_ADDR = {fcvr_pkg::REG_FIELD_MODE, 2'b00};

	localparam longint GAIN_Q30  = 64'sd652032874;
	localparam longint ONE_Q30   = 64'sd1073741824;
	localparam longint HALF_TURN = 64'sd2147483648;
	localparam longint QTR_TURN  = 64'sd1073741824;

	// atan(2^-i) in units of 2^-32 turn
	localparam longint ATAN_STEP [0:23] = '{
		536870912, 316933406, 167458907, 85004756, 42667331,
		21354465, 10680862, 5340245, 2670163, 1335087,
		667544, 333772, 166886, 83443, 41722,
		20861, 10430, 5215, 2608, 1304,
		652, 326, 163, 81
	};
	localparam int STEPS_USED = (ROT_STEPS > 24) ? 24 : ROT_STEPS;

	typedef struct {
		logic [1:0]              op;
		logic signed [15:0]      qw, qx, qy, qz;
		logic signed [VEL_W-1:0] vx, vy, om;
	} rot_word_t;

	typedef struct {
		logic signed [VEL_W-1:0] vx, vy, om;
		logic                    rotated;
	} vel_res_t;

	logic clk    = 1'b0;
	logic arst_n = 1'b0;

	logic        psel, penable, pwrite;
	logic [2:0]  paddr;
	logic [31:0] pwdata, prdata;
	logic        pready;

	fcvr_cmd_if #(.DATA_WIDTH(VEL_W)) cmd_ch ();
	fcvr_res_if #(.DATA_WIDTH(VEL_W)) res_ch ();

	field_centric_velocity_rotator_top #(
		.CORDIC_STEPS(ROT_STEPS),
		.DATA_WIDTH  (VEL_W)
	) u_dut (
		.clk    (clk),
		.arst_n (arst_n),
		.psel   (psel),
		.penable(penable),
		.pwrite (pwrite),
		.paddr  (paddr),
		.pwdata (pwdata),
		.prdata (prdata),
		.pready (pready),
		.cmd    (cmd_ch),
		.res    (res_ch)
	);

	always #(CLK_PERIOD / 2) clk = ~clk;

	// Predictor state and configuration
	logic [15:0] yaw_now;
	logic [15:0] yaw_offset;
	logic        odom_seen;
	logic        field_mode;

	rot_word_t word_backlog[$];
	vel_res_t  vel_due_q[$];
	rot_word_t drv_word;

	int words_queued;
	int words_sent;
	int mismatches;
	int n_odom, n_cmd, n_reset, n_spare, n_rotated, n_passed, n_mode_writes;
	int unsigned idle_pct;
	int hold_asked, hold_served, hold_left;
	int quiet_cycles;

	// atan2(y, x) by vectoring CORDIC, rounded to a 16-bit binary angle
	function automatic logic [15:0] heading_atan2(input longint cx, input longint sy);
		longint x, y, z, xs, ys;
		int i;
		x = cx;
		y = sy;
		z = 0;
		if (x == 0 && y == 0)
			return 16'h0000;
		if (x < 0) begin
			x = -x;
			y = -y;
			z = HALF_TURN;
		end
		for (i = 0; i < STEPS_USED; i++) begin
			xs = x >>> i;
			ys = y >>> i;
			if (y >= 0) begin
				x = x + ys;
				y = y - xs;
				z = z + ATAN_STEP[i];
			end else begin
				x = x - ys;
				y = y + xs;
				z = z - ATAN_STEP[i];
			end
		end
		return 16'((z + 32768) >>> 16);
	endfunction

	// cos/sin in Q.30 by rotation CORDIC, folded into the right half plane
	function automatic void heading_sincos(input logic [15:0] ang, output longint cs,
			output longint sn);
		longint x, y, z, xs, ys;
		logic flip;
		int i;
		z = longint'($signed({ang, 16'h0000}));
		x = GAIN_Q30;
		y = 0;
		flip = 1'b0;
		if (z > QTR_TURN) begin
			z = z - HALF_TURN;
			flip = 1'b1;
		end else if (z < -QTR_TURN) begin
			z = z + HALF_TURN;
			flip = 1'b1;
		end
		for (i = 0; i < STEPS_USED; i++) begin
			xs = x >>> i;
			ys = y >>> i;
			if (z >= 0) begin
				x = x - ys;
				y = y + xs;
				z = z - ATAN_STEP[i];
			end else begin
				x = x + ys;
				y = y - xs;
				z = z + ATAN_STEP[i];
			end
		end
		cs = flip ? -x : x;
		sn = flip ? -y : y;
	endfunction

	function automatic logic signed [VEL_W-1:0] round_q30_sat(input longint sum);
		longint v;
		longint hi;
		hi = (64'sd1 <<< (VEL_W - 1)) - 1;
		v = (sum + (ONE_Q30 >>> 1)) >>> 30;
		if (v > hi)
			v = hi;
		if (v < -hi - 1)
			v = -hi - 1;
		return VEL_W'(v);
	endfunction

	// Update heading state for a taken word; commands add one due result
	task automatic track_word(input rot_word_t w);
		longint s, c, cs, sn, vx, vy;
		vel_res_t r;
		vx = longint'(w.vx);
		vy = longint'(w.vy);
		case (w.op)
			fcvr_pkg::OP_ODOM: begin
				s = 2 * (longint'(w.qw) * longint'(w.qz) + longint'(w.qx) * longint'(w.qy));
				c = ONE_Q30 - 2 * (longint'(w.qy) * longint'(w.qy)
					+ longint'(w.qz) * longint'(w.qz));
				yaw_now = heading_atan2(c, s);
				if (!odom_seen) begin
					yaw_offset = yaw_now;
					odom_seen = 1'b1;
				end
				n_odom++;
			end
			fcvr_pkg::OP_RESET: begin
				yaw_offset = yaw_now;
				n_reset++;
			end
			fcvr_pkg::OP_CMD: begin
				r.om = w.om;
				if (field_mode && odom_seen) begin
					heading_sincos(yaw_now - yaw_offset, cs, sn);
					r.vx = round_q30_sat(vx * cs + vy * sn);
					r.vy = round_q30_sat(vy * cs - vx * sn);
					r.rotated = 1'b1;
					n_rotated++;
				end else begin
					r.vx = w.vx;
					r.vy = w.vy;
					r.rotated = 1'b0;
					n_passed++;
				end
				vel_due_q.push_back(r);
				n_cmd++;
			end
			default: n_spare++;
		endcase
	endtask

	task automatic report_mismatch(input string what, input longint got, input longint want);
		mismatches++;
		if (mismatches <= PRINT_CAP)
			$display("%0t mismatch on %s: got %0d, expected %0d", $realtime, what, got, want);
	endtask

	task automatic check_vel();
		vel_res_t want;
		if (vel_due_q.size() == 0) begin
			report_mismatch("res word with nothing due", 1, 0);
			return;
		end
		want = vel_due_q.pop_front();
		if (res_ch.out_vx !== want.vx)
			report_mismatch("out_vx", res_ch.out_vx, want.vx);
		if (res_ch.out_vy !== want.vy)
			report_mismatch("out_vy", res_ch.out_vy, want.vy);
		if (res_ch.out_omega !== want.om)
			report_mismatch("out_omega", res_ch.out_omega, want.om);
		if (res_ch.was_rotated !== want.rotated)
			report_mismatch("was_rotated", res_ch.was_rotated, want.rotated);
	endtask

	// Command side driver
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cmd_ch.valid <= 1'b0;
		end else begin
			if (cmd_ch.valid && cmd_ch.ready) begin
				track_word(drv_word);
				words_sent <= words_sent + 1;
			end
			if (!cmd_ch.valid || cmd_ch.ready) begin
				if (word_backlog.size() != 0 && $urandom_range(99) >= idle_pct) begin
					drv_word = word_backlog.pop_front();
					cmd_ch.valid     <= 1'b1;
					cmd_ch.operation <= drv_word.op;
					cmd_ch.quat_w    <= drv_word.qw;
					cmd_ch.quat_x    <= drv_word.qx;
					cmd_ch.quat_y    <= drv_word.qy;
					cmd_ch.quat_z    <= drv_word.qz;
					cmd_ch.cmd_vx    <= drv_word.vx;
					cmd_ch.cmd_vy    <= drv_word.vy;
					cmd_ch.omega_in  <= drv_word.om;
				end else begin
					cmd_ch.valid <= 1'b0;
				end
			end
		end
	end

	// Result side monitor, with a long hold-off on request
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_ch.ready <= 1'b0;
		end else begin
			if (res_ch.valid && res_ch.ready)
				check_vel();
			if (hold_asked != hold_served) begin
				hold_served <= hold_asked;
				hold_left <= HOLD_CYCLES;
				res_ch.ready <= 1'b0;
			end else if (hold_left != 0) begin
				hold_left <= hold_left - 1;
				res_ch.ready <= 1'b0;
			end else begin
				res_ch.ready <= ($urandom_range(99) >= idle_pct);
			end
		end
	end

	// Watchdog: too long with no word taken on either channel
	always @(posedge clk) begin
		if (arst_n) begin
			if ((cmd_ch.valid && cmd_ch.ready) || (res_ch.valid && res_ch.ready)) begin
				quiet_cycles <= 0;
			end else if (quiet_cycles >= QUIET_LIMIT) begin
				$display("timeout: no word taken for %0d cycles", QUIET_LIMIT);
				$display("FAIL field_centric_velocity_rotator_top");
				$finish;
			end else begin
				quiet_cycles <= quiet_cycles + 1;
			end
		end
	end

	task automatic write_reg(input logic [2:0] addr, input logic [31:0] val);
		@(posedge clk);
		psel    <= 1'b1;
		penable <= 1'b0;
		pwrite  <= 1'b1;
		paddr   <= addr;
		pwdata  <= val;
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
		psel    <= 1'b0;
		penable <= 1'b0;
		pwrite  <= 1'b0;
		if (addr == FIELD_MODE_ADDR)
			field_mode = val[0];
		n_mode_writes++;
	endtask

	task automatic queue_word(input rot_word_t w);
		word_backlog.push_back(w);
		words_queued++;
	endtask

	task automatic queue_fields(input logic [1:0] op, input int qw, input int qx, input int qy,
			input int qz, input int vx, input int vy, input int om);
		rot_word_t w;
		w.op = op;
		w.qw = 16'(qw);
		w.qx = 16'(qx);
		w.qy = 16'(qy);
		w.qz = 16'(qz);
		w.vx = VEL_W'(vx);
		w.vy = VEL_W'(vy);
		w.om = VEL_W'(om);
		queue_word(w);
	endtask

	// Wait until every word is taken and every due result has come
	task automatic wait_drained();
		while (words_sent != words_queued || vel_due_q.size() != 0)
			@(posedge clk);
	endtask

	task automatic settle();
		wait_drained();
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	function automatic rot_word_t random_word();
		rot_word_t w;
		int unsigned pick;
		pick = $urandom_range(99);
		w.qw = 16'($urandom());
		w.qx = 16'($urandom());
		w.qy = 16'($urandom());
		w.qz = 16'($urandom());
		w.vx = VEL_W'($urandom());
		w.vy = VEL_W'($urandom());
		w.om = VEL_W'($urandom());
		if (pick < 35) begin
			w.op = fcvr_pkg::OP_ODOM;
			// half the time near-level attitudes: small roll/pitch terms
			if ($urandom_range(1) == 0) begin
				w.qx = 16'($urandom_range(4095)) - 16'd2048;
				w.qy = 16'($urandom_range(4095)) - 16'd2048;
			end
		end else if (pick < 87) begin
			w.op = fcvr_pkg::OP_CMD;
			if ($urandom_range(9) == 0) begin
				w.vx = $urandom_range(1) ? 16'sh7fff : 16'sh8000;
				w.vy = $urandom_range(1) ? 16'sh7fff : 16'sh8000;
			end else if ($urandom_range(2) == 0) begin
				w.vx = 16'($urandom_range(2047)) - 16'd1024;
				w.vy = 16'($urandom_range(2047)) - 16'd1024;
			end
		end else if (pick < 96) begin
			w.op = fcvr_pkg::OP_RESET;
		end else begin
			w.op = OP_SPARE;
		end
		return w;
	endfunction

	initial begin
		rot_word_t w;
		int phase, k, n;
		cmd_ch.valid = 1'b0;
		cmd_ch.operation = fcvr_pkg::OP_ODOM;
		cmd_ch.quat_w = '0;
		cmd_ch.quat_x = '0;
		cmd_ch.quat_y = '0;
		cmd_ch.quat_z = '0;
		cmd_ch.cmd_vx = '0;
		cmd_ch.cmd_vy = '0;
		cmd_ch.omega_in = '0;
		res_ch.ready = 1'b0;
		psel = 1'b0;
		penable = 1'b0;
		pwrite = 1'b0;
		paddr = '0;
		pwdata = '0;
		yaw_now = '0;
		yaw_offset = '0;
		odom_seen = 1'b0;
		field_mode = 1'b1;
		words_queued = 0;
		words_sent = 0;
		mismatches = 0;
		{n_odom, n_cmd, n_reset, n_spare, n_rotated, n_passed, n_mode_writes} = '0;
		idle_pct = 34;
		hold_asked = 0;
		hold_served = 0;
		hold_left = 0;
		quiet_cycles = 0;

		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		write_reg(FIELD_MODE_ADDR, 32'd1);

		// Directed: commands and reset before odometry, degenerate and
		// extreme quaternions, quarter and half turns, saturation
		queue_fields(fcvr_pkg::OP_CMD, 0, 0, 0, 0, -32768, 32767, -32768);
		queue_fields(fcvr_pkg::OP_RESET, 0, 0, 0, 0, 0, 0, 0);
		queue_fields(OP_SPARE, -1, -1, -1, -1, -1, -1, -1);
		queue_fields(fcvr_pkg::OP_CMD, 0, 0, 0, 0, 100, -200, 5);
		queue_fields(fcvr_pkg::OP_ODOM, 0, 0, 0, 0, 0, 0, 0);
		queue_fields(fcvr_pkg::OP_CMD, 0, 0, 0, 0, 32767, -32768, 32767);
		queue_fields(fcvr_pkg::OP_ODOM, 23170, 0, 0, 23170, 0, 0, 0);
		queue_fields(fcvr_pkg::OP_CMD, 0, 0, 0, 0, 256, 512, 0);
		queue_fields(fcvr_pkg::OP_ODOM, 0, 0, 0, 32767, 0, 0, 0);
		queue_fields(fcvr_pkg::OP_CMD, 0, 0, 0, 0, -32768, -32768, 1);
		queue_fields(fcvr_pkg::OP_ODOM, -32768, -32768, -32768, -32768, 0, 0, 0);
		queue_fields(fcvr_pkg::OP_CMD, 0, 0, 0, 0, 1000, -1000, -1);
		queue_fields(fcvr_pkg::OP_ODOM, 32767, 32767, 32767, 32767, 0, 0, 0);
		queue_fields(fcvr_pkg::OP_ODOM, 23170, 0, 0, -23170, 0, 0, 0);
		queue_fields(fcvr_pkg::OP_CMD, 0, 0, 0, 0, 32767, 32767, 0);
		queue_fields(fcvr_pkg::OP_RESET, 0, 0, 0, 0, 0, 0, 0);
		queue_fields(fcvr_pkg::OP_CMD, 0, 0, 0, 0, -1, -1, -32768);
		queue_fields(fcvr_pkg::OP_ODOM, 0, 0, 32767, 0, 0, 0, 0);
		queue_fields(fcvr_pkg::OP_CMD, 0, 0, 0, 0, 0, 0, 0);
		queue_fields(fcvr_pkg::OP_ODOM, 30274, 0, 0, 12540, 0, 0, 0);
		queue_fields(fcvr_pkg::OP_CMD, 0, 0, 0, 0, -32768, 0, 32767);
		queue_fields(fcvr_pkg::OP_ODOM, 12540, 0, 0, 30274, 0, 0, 0);
		queue_fields(fcvr_pkg::OP_CMD, 0, 0, 0, 0, 0, 32767, 7);
		settle();

		// Field mode off: commands pass straight through
		write_reg(FIELD_MODE_ADDR, 32'd0);
		queue_fields(fcvr_pkg::OP_ODOM, 30274, 0, 0, -12540, 0, 0, 0);
		queue_fields(fcvr_pkg::OP_CMD, 0, 0, 0, 0, 32767, -32768, 0);
		queue_fields(fcvr_pkg::OP_CMD, 0, 0, 0, 0, -32768, 32767, -1);
		queue_fields(fcvr_pkg::OP_RESET, 0, 0, 0, 0, 0, 0, 0);
		queue_fields(fcvr_pkg::OP_CMD, 0, 0, 0, 0, 1234, -4321, 99);
		settle();

		// Random phases with the mode switched between them
		for (phase = 0; phase < 8; phase++) begin
			if (phase == 0 || phase == 1)
				write_reg(FIELD_MODE_ADDR, 32'd1);
			else if (phase == 4)
				write_reg(FIELD_MODE_ADDR, 32'd0);
			else
				write_reg(FIELD_MODE_ADDR, ($urandom_range(3) != 0) ? 32'd1 : 32'd0);
			idle_pct <= (phase == 1) ? 0 : 34;
			n = 245;
			if (phase == 2) begin
				// receiver holds off while commands keep coming
				hold_asked <= hold_asked + 1;
				for (k = 0; k < 40; k++) begin
					w = random_word();
					w.op = fcvr_pkg::OP_CMD;
					queue_word(w);
				end
				n = 205;
			end
			for (k = 0; k < n; k++) begin
				if (phase == 3 && k == n / 2)
					wait_drained();
				queue_word(random_word());
			end
			settle();
		end

		if (vel_due_q.size() != 0)
			report_mismatch("results still due at end", 0, vel_due_q.size());
		$display("taken: %0d odometry, %0d command, %0d heading reset, %0d spare-code words",
			n_odom, n_cmd, n_reset, n_spare);
		$display("results: %0d rotated, %0d passed through, %0d mode writes, %0d mismatches",
			n_rotated, n_passed, n_mode_writes, mismatches);
		if (mismatches == 0)
			$display("PASS field_centric_velocity_rotator_top");
		else
			$display("FAIL field_centric_velocity_rotator_top");
		$finish;
	end

endmodule

@@ field_centric_velocity_rotator_top.f @@
src/fcvr_pkg.sv
src/fcvr_ifs.sv
src/fcvr_smac.sv
src/fcvr_cordic.sv
src/field_centric_velocity_rotator_top.sv
sim/tb.sv
